[rtl/am_fm_multi_carrier_modulator_top_assert.svh]
// Assertion macros for the AM/FM multi-carrier modulator.
// Expects signals named clk and rst_n in the scope that uses them.
`ifndef AM_FM_MULTI_CARRIER_MODULATOR_TOP_ASSERT_SVH
`define AM_FM_MULTI_CARRIER_MODULATOR_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset
`define AMFM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amfm same-cycle assertion failed");
// Next-cycle implication, checked out of reset
`define AMFM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amfm next-cycle assertion failed");
`else
`define AMFM_ASSERT_IMP(label, ante, cons)
`define AMFM_ASSERT_NXT(label, ante, cons)
`endif
`endif

[rtl/amfm_pkg.sv]
// Shared types, constants and the sine table function of the AM/FM modulator.
// No dependencies.
package amfm_pkg;

  // Default geometry
  localparam int STATIONS_DEF        = 3;
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int PHASE_BITS_DEF      = 32;
  localparam int MAX_STATIONS        = 3;

  // Field and datapath widths
  localparam int AUDIO_W    = 16;
  localparam int GAIN_W     = 16;
  localparam int STEP_W     = 32;
  localparam int MODE_W     = 3;
  localparam int SAMPLE_W   = 35;
  localparam int ROM_W      = 15;
  localparam int SINE_W     = 16;
  localparam int OP_A_W     = 17;
  localparam int OP_B_W     = 33;
  localparam int PROD_W     = OP_A_W + OP_B_W;
  localparam int FM_SHIFT   = 15;
  localparam int OUT_SHIFT  = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;
  localparam logic [STEP_W-1:0] DEV_RST  = 32'd178956971;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_STEP_A = 3'd0;
  localparam cfg_idx_t REG_STEP_B = 3'd1;
  localparam cfg_idx_t REG_STEP_C = 3'd2;
  localparam cfg_idx_t REG_GAIN_A = 3'd3;
  localparam cfg_idx_t REG_GAIN_B = 3'd4;
  localparam cfg_idx_t REG_GAIN_C = 3'd5;
  localparam cfg_idx_t REG_MODES  = 3'd6;
  localparam cfg_idx_t REG_FM_DEV = 3'd7;

  typedef struct packed {
    logic [MAX_STATIONS-1:0][STEP_W-1:0] step;
    logic [MAX_STATIONS-1:0][GAIN_W-1:0] gain;
    logic [MODE_W-1:0]                   modes;
    logic [STEP_W-1:0]                   dev;
  } cfg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_AM_GAIN,
    ST_AM_SINE,
    ST_FM_DEV,
    ST_FM_OFS,
    ST_FM_ADDR,
    ST_FM_SINE,
    ST_ACC,
    ST_ROUND
  } seq_state_t;

  // Controls from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic mul_en;
    logic acc_clr;
    logic acc_add;
    logic acc_fm;
  } mac_ctrl_t;

  // Quarter-wave sine entry k, Q30 Taylor series with truncated steps
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

  function automatic logic [ROM_W-1:0] sine_entry(input int unsigned k,
                                                  input int unsigned tb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    x    = (64'(k) * HALF_PI_Q30) >> tb;
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    term = ONE_Q30 - (((x2 * term) >> 30) / 156);
    term = ONE_Q30 - (((x2 * term) >> 30) / 110);
    term = ONE_Q30 - (((x2 * term) >> 30) / 72);
    term = ONE_Q30 - (((x2 * term) >> 30) / 42);
    term = ONE_Q30 - (((x2 * term) >> 30) / 20);
    term = ONE_Q30 - (((x2 * term) >> 30) / 6);
    s    = (x * term) >> 30;
    s    = (s + (64'd1 << 14)) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[ROM_W-1:0];
  endfunction

endpackage

[rtl/amfm_if.sv]
// Handshake channels of the AM/FM modulator: audio in, antenna sample out.
// Depends on amfm_pkg.
interface amfm_in_if;
  import amfm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [AUDIO_W-1:0] audio_a;
  logic signed [AUDIO_W-1:0] audio_b;
  logic signed [AUDIO_W-1:0] audio_c;

  modport source (output valid, output audio_a, output audio_b, output audio_c,
                  input ready);
  modport sink (input valid, input audio_a, input audio_b, input audio_c,
                output ready);
endinterface

interface amfm_out_if;
  import amfm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] antenna_sample;

  modport source (output valid, output antenna_sample, input ready);
  modport sink (input valid, input antenna_sample, output ready);
endinterface

[rtl/am_fm_multi_carrier_modulator_top.sv]
// Three-station AM/FM carrier modulator: sequencer, phase state and outputs.
// Depends on amfm_pkg, amfm_if, amfm_sine_rom, amfm_mac, amfm_cfg_regs.
// An item carries one audio sample per station and yields one antenna sample.
// Stations are worked one after another through a single shared multiplier and
// a registered quarter-wave sine table; the block takes a new item only when
// idle. Each station starts from a start step; an AM station then runs gain,
// sine and accumulate steps, an FM station deviation, offset, address, sine and
// accumulate steps. A finished sample waits in the output register, so the
// next item can be taken while it is unclaimed; that item then holds in its
// rounding step until the earlier sample is taken.
// The user writes configuration through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this.
`include "am_fm_multi_carrier_modulator_top_assert.svh"
module am_fm_multi_carrier_modulator_top #(
  parameter int STATIONS        = amfm_pkg::STATIONS_DEF,
  parameter int SINE_TABLE_BITS = amfm_pkg::SINE_TABLE_BITS_DEF,
  parameter int PHASE_BITS      = amfm_pkg::PHASE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  amfm_in_if.sink                         in_ch,
  amfm_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  amfm_pkg::cfg_idx_t              cfg_index,
  input  logic [amfm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import amfm_pkg::*;

  localparam int STW = $clog2(STATIONS + 1);
  localparam int PB  = PHASE_BITS;
  localparam logic [PB-1:0] QUARTER = PB'(1) << (PB - 2);

  cfg_t       cfg;
  seq_state_t state_r, state_nxt;
  logic [STW-1:0] st_r, st_nxt;
  logic signed [AUDIO_W-1:0] audio_r [MAX_STATIONS];
  logic signed [AUDIO_W-1:0] audio_nxt [MAX_STATIONS];
  logic [PB-1:0] phase_r [STATIONS];
  logic [PB-1:0] phase_nxt [STATIONS];
  logic [PB-1:0] ofs_r [STATIONS];
  logic [PB-1:0] ofs_nxt [STATIONS];
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic signed [AUDIO_W-1:0] cur_audio;
  logic [GAIN_W-1:0]         cur_gain;
  logic [PB-1:0]             cur_phase;
  logic [PB-1:0]             cur_ofs;
  logic [PB-1:0]             cur_step;
  logic                      cur_fm;
  logic [PB-1:0]             rom_phase;
  logic signed [SINE_W-1:0]  sine;
  logic signed [OP_A_W-1:0]  op_a;
  logic signed [OP_B_W-1:0]  op_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [SAMPLE_W-1:0] rnd;
  mac_ctrl_t                 mac_ctrl;
  logic                      accept;

  amfm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg_o    (cfg)
  );

  amfm_sine_rom #(.TB(SINE_TABLE_BITS), .PB(PB)) u_rom (
    .clk    (clk),
    .phase_i(rom_phase),
    .sine_o (sine)
  );

  amfm_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_o (prod),
    .round_o(rnd)
  );

  // Select the station being worked
  always_comb begin
    cur_audio = '0;
    cur_gain  = '0;
    cur_phase = '0;
    cur_ofs   = '0;
    cur_step  = '0;
    cur_fm    = 1'b0;
    for (int i = 0; i < STATIONS; i++) begin
      if (st_r == STW'(i)) begin
        cur_audio = audio_r[i];
        cur_gain  = cfg.gain[i];
        cur_phase = phase_r[i];
        cur_ofs   = ofs_r[i];
        cur_step  = cfg.step[i][PB-1:0];
        cur_fm    = cfg.modes[i];
      end
    end
    rom_phase = cur_fm ? (cur_phase + cur_ofs + QUARTER) : cur_phase;
  end

  // Steer the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      ST_AM_GAIN: begin
        op_a = $signed({1'b0, cur_gain});
        op_b = $signed({17'b0, ~cur_audio[AUDIO_W-1], cur_audio[AUDIO_W-2:0]});
      end
      ST_AM_SINE: begin
        op_a = $signed({sine[SINE_W-1], sine});
        op_b = $signed({1'b0, prod[31:0]});
      end
      ST_FM_DEV: begin
        op_a = $signed({cur_audio[AUDIO_W-1], cur_audio});
        op_b = $signed({1'b0, cfg.dev});
      end
      ST_FM_SINE: begin
        op_a = $signed({sine[SINE_W-1], sine});
        op_b = $signed({17'b0, cur_gain});
      end
      default: ;
    endcase
  end

  // Sequencer: next state, station state and output register
  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    audio_nxt     = audio_r;
    phase_nxt     = phase_r;
    ofs_nxt       = ofs_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    accept        = 1'b0;
    mac_ctrl      = '0;
    mac_ctrl.acc_fm = cur_fm;

    // drop the result once it is taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          accept           = 1'b1;
          mac_ctrl.acc_clr = 1'b1;
          audio_nxt[0]     = in_ch.audio_a;
          audio_nxt[1]     = in_ch.audio_b;
          audio_nxt[2]     = in_ch.audio_c;
          st_nxt           = '0;
          state_nxt        = ST_START;
        end
      end
      ST_START: begin
        if (st_r == STW'(STATIONS)) begin
          state_nxt = ST_ROUND;
        end else if (cur_fm) begin
          state_nxt = ST_FM_DEV;
        end else begin
          state_nxt = ST_AM_GAIN;
        end
      end
      ST_AM_GAIN: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = ST_AM_SINE;
      end
      ST_AM_SINE: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = ST_ACC;
      end
      ST_FM_DEV: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = ST_FM_OFS;
      end
      ST_FM_OFS: begin
        for (int i = 0; i < STATIONS; i++) begin
          if (st_r == STW'(i)) begin
            ofs_nxt[i] = ofs_r[i] + prod[FM_SHIFT +: PB];
          end
        end
        state_nxt = ST_FM_ADDR;
      end
      ST_FM_ADDR: begin
        state_nxt = ST_FM_SINE;
      end
      ST_FM_SINE: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_add = 1'b1;
        for (int i = 0; i < STATIONS; i++) begin
          if (st_r == STW'(i)) begin
            phase_nxt[i] = phase_r[i] + cur_step;
          end
        end
        st_nxt    = st_r + STW'(1);
        state_nxt = ST_START;
      end
      ST_ROUND: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rnd;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      st_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STATIONS; i++) begin
        phase_r[i] <= '0;
        ofs_r[i]   <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      st_r        <= st_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      ofs_r       <= ofs_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    audio_r    <= audio_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.antenna_sample = out_data_r;

  // Checks
  `AMFM_ASSERT_NXT(a_accept_busy, accept, !in_ch.ready)
  `AMFM_ASSERT_IMP(a_station_bound, state_r != ST_IDLE, st_r <= STW'(STATIONS))
  `AMFM_ASSERT_IMP(a_am_order, state_r == ST_AM_SINE, $past(state_r) == ST_AM_GAIN)
  `AMFM_ASSERT_NXT(a_out_load, state_r == ST_ROUND && (!out_valid_r || out_ch.ready), out_ch.valid && in_ch.ready)
endmodule

[rtl/amfm_sine_rom.sv]
// Quarter-wave sine lookup with quadrant folding and a registered output.
// Depends on amfm_pkg (sine_entry).
module amfm_sine_rom #(
  parameter int TB = amfm_pkg::SINE_TABLE_BITS_DEF,
  parameter int PB = amfm_pkg::PHASE_BITS_DEF
) (
  input  logic                              clk,
  input  logic [PB-1:0]                     phase_i,
  output logic signed [amfm_pkg::SINE_W-1:0] sine_o
);
  import amfm_pkg::*;

  localparam int ROM_N = 1 << TB;
  localparam int AW    = TB + 1;

  logic [ROM_W-1:0]        tbl [ROM_N+1];
  logic [TB+1:0]           idx;
  logic [1:0]              quad;
  logic [TB-1:0]           k;
  logic [AW-1:0]           addr;
  logic [ROM_W-1:0]        mag;
  logic signed [SINE_W-1:0] sine_nxt;
  logic signed [SINE_W-1:0] sine_r;

  // Constant quarter-wave table
  for (genvar g = 0; g <= ROM_N; g++) begin : g_tbl
    assign tbl[g] = sine_entry(g, TB);
  end

  // Fold the phase into the first quadrant
  always_comb begin
    idx  = phase_i[PB-1 -: TB+2];
    quad = idx[TB+1:TB];
    k    = idx[TB-1:0];
    addr = quad[0] ? (AW'(ROM_N) - {1'b0, k}) : {1'b0, k};
    mag  = tbl[addr];
    sine_nxt = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  // Register the lookup
  always_ff @(posedge clk) begin
    sine_r <= sine_nxt;
  end

  assign sine_o = sine_r;
endmodule

[rtl/amfm_mac.sv]
// Shared multiply-accumulate unit: one 17x33 signed multiplier with a
// registered product, a sum register and the final rounding. Depends on amfm_pkg.
module amfm_mac (
  input  logic                               clk,
  input  amfm_pkg::mac_ctrl_t                ctrl,
  input  logic signed [amfm_pkg::OP_A_W-1:0] op_a,
  input  logic signed [amfm_pkg::OP_B_W-1:0] op_b,
  output logic signed [amfm_pkg::PROD_W-1:0] prod_o,
  output logic signed [amfm_pkg::SAMPLE_W-1:0] round_o
);
  import amfm_pkg::*;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] acc_r;
  logic signed [PROD_W-1:0] acc_nxt;
  logic signed [PROD_W-1:0] term;
  logic signed [PROD_W-1:0] rnd_sum;

  // Multiply, align the term and round the sum
  always_comb begin
    prod_nxt = op_a * op_b;
    term     = ctrl.acc_fm ? (prod_r <<< FM_SHIFT) : prod_r;
    acc_nxt  = acc_r + term;
    rnd_sum  = acc_r + (PROD_W'(1) << (OUT_SHIFT - 1));
  end

  // Hold the product and the running sum
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_nxt;
    end
  end

  assign prod_o  = prod_r;
  assign round_o = rnd_sum[OUT_SHIFT +: SAMPLE_W];
endmodule

[rtl/amfm_cfg_regs.sv]
// Configuration register file of the AM/FM modulator.
// Depends on amfm_pkg.
module amfm_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  amfm_pkg::cfg_idx_t                  cfg_index,
  input  logic [amfm_pkg::CFG_DATA_W-1:0]     cfg_data,
  output amfm_pkg::cfg_t                      cfg_o
);
  import amfm_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode a write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_STEP_A: cfg_nxt.step[0] = cfg_data[STEP_W-1:0];
        REG_STEP_B: cfg_nxt.step[1] = cfg_data[STEP_W-1:0];
        REG_STEP_C: cfg_nxt.step[2] = cfg_data[STEP_W-1:0];
        REG_GAIN_A: cfg_nxt.gain[0] = cfg_data[GAIN_W-1:0];
        REG_GAIN_B: cfg_nxt.gain[1] = cfg_data[GAIN_W-1:0];
        REG_GAIN_C: cfg_nxt.gain[2] = cfg_data[GAIN_W-1:0];
        REG_MODES:  cfg_nxt.modes   = cfg_data[MODE_W-1:0];
        REG_FM_DEV: cfg_nxt.dev     = cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step  <= '0;
      cfg_r.gain  <= {MAX_STATIONS{GAIN_RST}};
      cfg_r.modes <= '0;
      cfg_r.dev   <= DEV_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;
endmodule
